[rtl/core/edpd_pkg.sv]
package edpd_pkg;

  // Channel format and derived widths.
  localparam int COLOR_BITS    = 16;
  localparam int ERR_W         = COLOR_BITS + 1;
  localparam int LANES         = 3;
  localparam int PALETTE_DEPTH = 16;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);

  // Configuration registers.
  localparam int COUNT_W     = 5;
  localparam int INTENSITY_W = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY   = 1'd1;

  localparam logic [COUNT_W-1:0]     COLOR_COUNT_RST = 5'd16;
  localparam logic [INTENSITY_W-1:0] INTENSITY_RST   = 9'd192;

  // Command codes.
  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_DITHER    = 1'b1;

  // Tap weights, round(65536 / (k + 1)) with halves rounded up.
  localparam int WEIGHT_W  = 17;
  localparam int TAP_SEL_W = 4;

  typedef logic signed [COLOR_BITS-1:0] color_t;
  typedef logic signed [ERR_W-1:0]      err_t;

  typedef struct packed {
    logic             cmd;
    logic             frame_start;
    logic [IDX_W-1:0] entry_index;
    color_t           chan_l;
    color_t           chan_a;
    color_t           chan_b;
  } edpd_pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    color_t           out_l;
    color_t           out_a;
    color_t           out_b;
  } edpd_result_t;

  typedef struct packed {
    logic clear;
    logic push;
  } hist_ctl_t;

  function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [TAP_SEL_W-1:0] k);
    logic [WEIGHT_W-1:0] w;
    case (k)
      4'd0:    w = 17'd65536;
      4'd1:    w = 17'd32768;
      4'd2:    w = 17'd21845;
      4'd3:    w = 17'd16384;
      4'd4:    w = 17'd13107;
      4'd5:    w = 17'd10923;
      4'd6:    w = 17'd9362;
      4'd7:    w = 17'd8192;
      4'd8:    w = 17'd7282;
      4'd9:    w = 17'd6554;
      4'd10:   w = 17'd5958;
      4'd11:   w = 17'd5461;
      4'd12:   w = 17'd5041;
      4'd13:   w = 17'd4681;
      4'd14:   w = 17'd4369;
      4'd15:   w = 17'd4096;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/error_diffusion_palette_dither_core.sv]
// Channel  | Signals                               | Direction | Content
// pixel    | pixel_valid, pixel_stall, pixel       | in        | palette write or pixel
// result   | result_valid, result_stall, result    | out       | chosen index and colour
// config   | cfg_write, cfg_index, cfg_data        | in        | colour count, intensity
//
// A palette write does not stall the pixel channel. A pixel transaction holds
// pixel_stall high while the one three-lane multiplier walks the error taps, scales
// the weighted sum by the intensity and then walks the palette entries.
// Synchronous reset clears the error history and restores the register defaults;
// the palette holds nothing defined until it is written, and needs no clearing pass.
// The result sits in an output register; the next pixel is accepted while it waits,
// and a pixel only stalls at its final step if that register is still occupied.
module error_diffusion_palette_dither_core import edpd_pkg::*; #(
  parameter int HISTORY_TAPS = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  edpd_pixel_t            pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output edpd_result_t           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Tap counter and history select.
  localparam int TAP_W = (HISTORY_TAPS > 1) ? $clog2(HISTORY_TAPS) : 1;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(HISTORY_TAPS - 1);

  // Weighted error sum A = sum(err * W). It is later split into a low part of
  // LO_W unsigned bits and a signed high part so that each fits the multiplier.
  localparam int ACC_W = ERR_W + WEIGHT_W + $clog2(HISTORY_TAPS) + 2;
  localparam int LO_W  = 17;
  localparam int MAC_W = ACC_W - LO_W;

  // Scaled sum S = intensity * A, with the rounding offset folded in.
  localparam int SCALE_SHIFT = 24;
  localparam int SUM_W       = ACC_W + INTENSITY_W + 2;
  localparam int TGT_W       = SUM_W - SCALE_SHIFT + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (SCALE_SHIFT - 1));
  localparam logic signed [TGT_W-1:0] COLOR_MAX  = TGT_W'((2 ** (COLOR_BITS - 1)) - 1);
  localparam logic signed [TGT_W-1:0] COLOR_MIN  = TGT_W'(-(2 ** (COLOR_BITS - 1)));

  localparam int DIST_W = 2 * ERR_W;
  localparam int SCNT_W = $clog2(PALETTE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAPS,
    ST_TAPS_END,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_SCALE_SUM,
    ST_TARGET,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic color_t sat_color(input logic signed [TGT_W-1:0] v);
    color_t r;
    if (v > COLOR_MAX) begin
      r = COLOR_MAX[COLOR_BITS-1:0];
    end else if (v < COLOR_MIN) begin
      r = COLOR_MIN[COLOR_BITS-1:0];
    end else begin
      r = v[COLOR_BITS-1:0];
    end
    return r;
  endfunction

  state_t                   state;
  logic [COUNT_W-1:0]       color_count;
  logic [INTENSITY_W-1:0]   intensity;

  color_t                   src [LANES];
  color_t                   tgt [LANES];
  logic [TAP_W-1:0]         tap;
  logic                     acc_en;
  logic signed [ACC_W-1:0]  acc [LANES];
  logic signed [SUM_W-1:0]  sacc [LANES];
  logic signed [TGT_W-1:0]  tsum [LANES];

  logic [SCNT_W-1:0]        scnt;
  logic [SCNT_W-1:0]        cnt_lim;

  // Search pipeline: read, difference, square, distance, compare.
  logic                     v1, v2, v3, v4;
  logic [IDX_W-1:0]         idx1, idx2, idx3, idx4;
  color_t                   pal2 [LANES];
  color_t                   pal3 [LANES];
  color_t                   pal4 [LANES];
  err_t                     diff2 [LANES];
  logic [DIST_W-1:0]        dist4;

  logic                     first;
  logic [DIST_W-1:0]        best_d;
  logic [IDX_W-1:0]         best_idx;
  color_t                   best_pal [LANES];

  logic signed [MAC_W-1:0]   mac_a [LANES];
  logic signed [MAC_W-1:0]   mac_b [LANES];
  logic signed [2*MAC_W-1:0] prod [LANES];

  hist_ctl_t                hctl;
  err_t                     push_err [LANES];
  err_t                     tap_err [LANES];

  logic                     ram_we;
  logic [LANES*COLOR_BITS-1:0] ram_rdata;
  color_t                   rd_pal [LANES];

  logic                     pix_acc;
  logic                     out_free;

  // A new transaction is only taken while the sequencer is idle.
  assign pixel_stall = (state != ST_IDLE);
  assign pix_acc     = pixel_valid && !pixel_stall;
  assign out_free    = !result_valid || !result_stall;
  assign ram_we      = pix_acc && (pixel.cmd == CMD_PAL_WRITE);

  // Palette entries hold the three channels packed, first channel at the top.
  edpd_ram #(
    .WIDTH (LANES * COLOR_BITS),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pixel.entry_index),
    .wdata ({pixel.chan_l, pixel.chan_a, pixel.chan_b}),
    .raddr (scnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      rd_pal[c] = ram_rdata[(LANES-1-c)*COLOR_BITS +: COLOR_BITS];
    end
  end

  // History is cleared by a frame start on a pixel, never on a palette write.
  assign hctl.clear = pix_acc && (pixel.cmd == CMD_DITHER) && pixel.frame_start;
  assign hctl.push  = (state == ST_DONE) && out_free;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      push_err[c] = ERR_W'(best_pal[c]) - ERR_W'(src[c]);
    end
  end

  edpd_hist #(
    .TAPS (HISTORY_TAPS)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hctl),
    .push_err (push_err),
    .sel      (tap),
    .tap_err  (tap_err)
  );

  // Operand selection for the shared multiplier. While taps are walked it forms
  // err * weight; then the two halves of the sum are scaled by the intensity;
  // during the search it squares the channel differences.
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      case (state)
        ST_TAPS: begin
          mac_a[c] = MAC_W'(tap_err[c]);
          mac_b[c] = MAC_W'(signed'({1'b0, tap_weight(TAP_SEL_W'(tap))}));
        end
        ST_SCALE_LO: begin
          mac_a[c] = MAC_W'(signed'({1'b0, acc[c][LO_W-1:0]}));
          mac_b[c] = MAC_W'(signed'({1'b0, intensity}));
        end
        ST_SCALE_HI: begin
          mac_a[c] = MAC_W'(acc[c] >>> LO_W);
          mac_b[c] = MAC_W'(signed'({1'b0, intensity}));
        end
        default: begin
          mac_a[c] = MAC_W'(diff2[c]);
          mac_b[c] = MAC_W'(diff2[c]);
        end
      endcase
    end
  end

  edpd_mac #(
    .W (MAC_W)
  ) u_mac (
    .clk  (clk),
    .op_a (mac_a),
    .op_b (mac_b),
    .prod (prod)
  );

  // The correction is floor((2^23 - S) / 2^24), held in sacc before the shift.
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      tsum[c] = TGT_W'(sacc[c] >>> SCALE_SHIFT) + TGT_W'(src[c]);
    end
  end

  // A colour count of zero searches one entry; anything above the depth is capped.
  always_comb begin
    if (color_count == '0) begin
      cnt_lim = SCNT_W'(1);
    end else if (color_count > COUNT_W'(PALETTE_DEPTH)) begin
      cnt_lim = SCNT_W'(PALETTE_DEPTH);
    end else begin
      cnt_lim = SCNT_W'(color_count);
    end
  end

  // Sequencer, configuration registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      color_count  <= COLOR_COUNT_RST;
      intensity    <= INTENSITY_RST;
      acc_en       <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      first        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COLOR_COUNT: color_count <= cfg_data[COUNT_W-1:0];
          REG_INTENSITY:   intensity   <= cfg_data[INTENSITY_W-1:0];
          default: ;
        endcase
      end

      // In the finishing state the result register is reloaded further down.
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end

      acc_en <= (state == ST_TAPS);
      v1     <= (state == ST_SEARCH);
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      if (v4) begin
        first <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (pix_acc && (pixel.cmd == CMD_DITHER)) begin
            state <= ST_TAPS;
          end
        end
        ST_TAPS: begin
          if (tap == TAP_LAST) begin
            state <= ST_TAPS_END;
          end
        end
        ST_TAPS_END:  state <= ST_SCALE_LO;
        ST_SCALE_LO:  state <= ST_SCALE_HI;
        ST_SCALE_HI:  state <= ST_SCALE_SUM;
        ST_SCALE_SUM: state <= ST_TARGET;
        ST_TARGET: begin
          state <= ST_SEARCH;
          first <= 1'b1;
        end
        ST_SEARCH: begin
          if (scnt == cnt_lim - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2 && !v3 && !v4) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state              <= ST_IDLE;
            result_valid       <= 1'b1;
            result.color_index <= best_idx;
            result.out_l       <= best_pal[0];
            result.out_a       <= best_pal[1];
            result.out_b       <= best_pal[2];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        tap  <= '0;
        scnt <= '0;
        if (pix_acc) begin
          src[0] <= pixel.chan_l;
          src[1] <= pixel.chan_a;
          src[2] <= pixel.chan_b;
        end
      end
      ST_TAPS:   tap  <= tap + 1'b1;
      ST_SEARCH: scnt <= scnt + 1'b1;
      default: ;
    endcase

    for (int c = 0; c < LANES; c++) begin
      if (state == ST_IDLE) begin
        acc[c] <= '0;
      end else if (acc_en) begin
        acc[c] <= acc[c] + ACC_W'(prod[c]);
      end

      if (state == ST_SCALE_HI) begin
        sacc[c] <= ROUND_HALF - SUM_W'(prod[c]);
      end else if (state == ST_SCALE_SUM) begin
        sacc[c] <= sacc[c] - (SUM_W'(prod[c]) <<< LO_W);
      end

      if (state == ST_TARGET) begin
        tgt[c] <= sat_color(tsum[c]);
      end

      diff2[c] <= ERR_W'(rd_pal[c]) - ERR_W'(tgt[c]);
      pal2[c]  <= rd_pal[c];
      pal3[c]  <= pal2[c];
      pal4[c]  <= pal3[c];
    end

    idx1  <= scnt[IDX_W-1:0];
    idx2  <= idx1;
    idx3  <= idx2;
    idx4  <= idx3;
    dist4 <= prod[0][DIST_W-1:0] + prod[1][DIST_W-1:0] + prod[2][DIST_W-1:0];

    // Strict compare keeps the lowest index on a tie.
    if (v4 && (first || (dist4 < best_d))) begin
      best_d   <= dist4;
      best_idx <= idx4;
      best_pal <= pal4;
    end
  end

`ifndef ASSERT_OFF
  a_search_in_phase: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (state == ST_SEARCH || state == ST_DRAIN))
    else $error("search pipeline active outside the search phase");

  a_acc_window: assert property (@(posedge clk) disable iff (rst)
    acc_en |-> (state == ST_TAPS || state == ST_TAPS_END))
    else $error("tap accumulation outside the tap walk");

  a_busy_after_pixel: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && (pixel.cmd == CMD_DITHER)) |=> pixel_stall)
    else $error("pixel transaction did not start the sequencer");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (SCNT_W'(best_idx) < cnt_lim))
    else $error("chosen entry lies beyond the searched palette");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result raised without a finished pixel");
`endif

endmodule

[rtl/core/edpd_ram.sv]
module edpd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/edpd_mac.sv]
module edpd_mac import edpd_pkg::*; #(
  parameter int W = 21
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   op_a [LANES],
  input  logic signed [W-1:0]   op_b [LANES],
  output logic signed [2*W-1:0] prod [LANES]
);

  // One registered multiplier per colour channel, shared by every phase.
  always_ff @(posedge clk) begin
    for (int c = 0; c < LANES; c++) begin
      prod[c] <= op_a[c] * op_b[c];
    end
  end

endmodule

[rtl/core/edpd_hist.sv]
module edpd_hist import edpd_pkg::*; #(
  parameter int TAPS = 7,
  localparam int SEL_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  hist_ctl_t        ctl,
  input  err_t             push_err [LANES],
  input  logic [SEL_W-1:0] sel,
  output err_t             tap_err [LANES]
);

  err_t hist [TAPS][LANES];

  // Newest error sits in entry zero; older ones move up one place per push.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int k = 0; k < TAPS; k++) begin
        for (int c = 0; c < LANES; c++) begin
          hist[k][c] <= '0;
        end
      end
    end else if (ctl.push) begin
      for (int k = TAPS - 1; k > 0; k--) begin
        hist[k] <= hist[k-1];
      end
      hist[0] <= push_err;
    end
  end

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      tap_err[c] = hist[sel][c];
    end
  end

endmodule
